>>> hdl/ypdm_pkg.sv
// Shared types, constants and helpers for the yaw PD differential mixer.
// Self-contained; imported by ypdm_cfg, yaw_pd_differential_mixer, wheel_cmd_checker and tb.
package ypdm_pkg;

  // Angle handling, 0.01 degree units
  localparam logic signed [17:0] HALF_TURN = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;

  // Rounding and scaling of the Q8.8 * 0.01 degree product (scale 25600 = 256 * 100)
  localparam logic [36:0] GAIN_HALF = 37'd12800;
  // Quotient by 100 reaches 4096 or more: saturate instead of dividing
  localparam logic [28:0] SAT_LEVEL = 29'd409600;
  // ceil(2^26 / 100), exact floor division by 100 for inputs below 2^19
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam int unsigned RECIP_SHIFT = 26;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_TARGET  = 3'd1,
    REG_BASE    = 3'd2,
    REG_PGAIN   = 3'd3,
    REG_RGAIN   = 3'd4,
    REG_INVERT  = 3'd5,
    REG_CLIMIT  = 3'd6,
    REG_TLIMIT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ZERO = 2'd1,
    ACT_CMD  = 2'd2
  } action_e;

  typedef struct packed {
    logic               enable;
    logic signed [15:0] target_yaw;
    logic signed [12:0] base_speed;
    logic [15:0]        prop_gain;
    logic [15:0]        rate_gain;
    logic               invert_direction;
    logic [11:0]        correction_limit;
    logic [11:0]        target_limit;
  } cfg_t;

  // Wrap an angle difference into [-18000, 18000]; one step covers all inputs here
  function automatic logic signed [15:0] wrap_angle(input logic signed [16:0] a);
    logic signed [17:0] w;
    w = 18'(a);
    if (w > HALF_TURN) begin
      w = w - FULL_TURN;
    end else if (w < -HALF_TURN) begin
      w = w + FULL_TURN;
    end
    return signed'(w[15:0]);
  endfunction

  // Clamp a signed speed to +-lim
  function automatic logic signed [13:0] clamp_mag(input logic signed [13:0] v,
                                                   input logic [11:0] lim);
    logic signed [13:0] s;
    s = signed'({2'b00, lim});
    if (v > s) begin
      return s;
    end else if (v < -s) begin
      return -s;
    end
    return v;
  endfunction

endpackage

>>> hdl/ypdm_cfg.sv
// Configuration register file of the yaw PD mixer: wraps the target heading
// and clamps the base speed on write. Depends on ypdm_pkg.
module ypdm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ypdm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ypdm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output ypdm_pkg::cfg_t                     cfg_o
);
  import ypdm_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic signed [13:0] base_clamped;

  // Base speed is clamped against the limit held at write time
  assign base_clamped = clamp_mag(14'(signed'(cfg_data_i[12:0])), cfg_q.target_limit);

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_ENABLE: cfg_d.enable           = cfg_data_i[0];
        REG_TARGET: cfg_d.target_yaw       = wrap_angle(17'(signed'(cfg_data_i)));
        REG_BASE:   cfg_d.base_speed       = base_clamped[12:0];
        REG_PGAIN:  cfg_d.prop_gain        = cfg_data_i;
        REG_RGAIN:  cfg_d.rate_gain        = cfg_data_i;
        REG_INVERT: cfg_d.invert_direction = cfg_data_i[0];
        REG_CLIMIT: cfg_d.correction_limit = cfg_data_i[11:0];
        REG_TLIMIT: cfg_d.target_limit     = cfg_data_i[11:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/yaw_pd_differential_mixer.sv
// Yaw PD heading controller with differential-drive mixing.
// Pipeline: input register, product stage, rounding stage, divide-by-100 multiply stage,
// result register. Throughput: one request per cycle unless the pipe is full behind a
// held result; each stage has its own valid, so bubbles absorb stalls.
// Reset (async, active low) clears all stage valids and every configuration register.
module yaw_pd_differential_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [ypdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ypdm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              current_yaw_i,
  input  logic signed [18:0]              yaw_rate_i,
  input  logic                            gyro_ready_i,
  input  logic [15:0]                     period_us_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ypdm_pkg::action_e               action_o,
  output logic signed [12:0]              left_speed_o,
  output logic signed [12:0]              right_speed_o,
  output logic signed [12:0]              correction_o
);
  import ypdm_pkg::*;

  cfg_t cfg;

  ypdm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage valids and advance chain
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic adv1, adv2, adv3, adv4, advo;

  assign advo = !vo_q || out_ready_i;
  assign adv4 = !v4_q || advo;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (advo) vo_q <= v4_q;
    end
  end

  // Stage 1: input register, action decided up front
  action_e            s1_act_d, s1_act_q;
  logic signed [15:0] s1_yaw_q;
  logic signed [18:0] s1_rate_q;

  always_comb begin
    if (!cfg.enable || (period_us_i == '0)) begin
      s1_act_d = ACT_NONE;
    end else if (!gyro_ready_i) begin
      s1_act_d = ACT_ZERO;
    end else begin
      s1_act_d = ACT_CMD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_act_q  <= s1_act_d;
      s1_yaw_q  <= current_yaw_i;
      s1_rate_q <= yaw_rate_i;
    end
  end

  // Stage 2: heading error and the two gain products
  logic signed [16:0] yaw_diff;
  logic signed [15:0] yaw_err;
  logic signed [32:0] s2_pp_d, s2_pp_q;
  logic signed [35:0] s2_rp_d, s2_rp_q;
  action_e            s2_act_q;

  assign yaw_diff = 17'(cfg.target_yaw) - 17'(s1_yaw_q);
  assign yaw_err  = wrap_angle(yaw_diff);
  assign s2_pp_d  = 33'(signed'({1'b0, cfg.prop_gain})) * 33'(yaw_err);
  assign s2_rp_d  = 36'(signed'({1'b0, cfg.rate_gain})) * 36'(s1_rate_q);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_act_q <= s1_act_q;
      s2_pp_q  <= s2_pp_d;
      s2_rp_q  <= s2_rp_d;
    end
  end

  // Stage 3: difference, direction, magnitude, round and drop the Q8 fraction
  logic signed [36:0] num_raw, num;
  logic [36:0]        mag_full;
  logic [36:0]        rounded;
  logic [28:0]        scaled;
  logic               s3_neg_q, s3_sat_q;
  logic [18:0]        s3_y_q;
  action_e            s3_act_q;

  assign num_raw  = 37'(s2_pp_q) - 37'(s2_rp_q);
  assign num      = cfg.invert_direction ? -num_raw : num_raw;
  assign mag_full = num[36] ? unsigned'(-num) : unsigned'(num);
  assign rounded  = {1'b0, mag_full[35:0]} + GAIN_HALF;
  assign scaled   = rounded[36:8];

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_act_q <= s2_act_q;
      s3_neg_q <= num[36];
      s3_sat_q <= (scaled >= SAT_LEVEL);
      s3_y_q   <= scaled[18:0];
    end
  end

  // Stage 4: divide by 100 through a reciprocal multiply
  logic [38:0] s4_qp_q;
  logic        s4_neg_q, s4_sat_q;
  action_e     s4_act_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      s4_act_q <= s3_act_q;
      s4_neg_q <= s3_neg_q;
      s4_sat_q <= s3_sat_q;
      s4_qp_q  <= 39'(s3_y_q) * 39'(RECIP_100);
    end
  end

  // Result stage: clamp correction, mix into wheels, clamp wheels
  logic [11:0]        quot;
  logic [11:0]        corr_mag;
  logic signed [13:0] corr;
  logic signed [13:0] left_mix, right_mix;
  logic signed [12:0] left_d, right_d, corr_d;
  action_e            act_q;
  logic signed [12:0] left_q, right_q, corr_q;

  assign quot     = s4_qp_q[RECIP_SHIFT+11:RECIP_SHIFT];
  assign corr_mag = (s4_sat_q || (quot > cfg.correction_limit)) ? cfg.correction_limit : quot;
  assign corr     = s4_neg_q ? -signed'({2'b00, corr_mag}) : signed'({2'b00, corr_mag});
  assign left_mix  = clamp_mag(14'(cfg.base_speed) - corr, cfg.target_limit);
  assign right_mix = clamp_mag(14'(cfg.base_speed) + corr, cfg.target_limit);

  always_comb begin
    if (s4_act_q == ACT_CMD) begin
      left_d  = left_mix[12:0];
      right_d = right_mix[12:0];
      corr_d  = corr[12:0];
    end else begin
      left_d  = '0;
      right_d = '0;
      corr_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advo) begin
      act_q   <= s4_act_q;
      left_q  <= left_d;
      right_q <= right_d;
      corr_q  <= corr_d;
    end
  end

  assign out_valid_o   = vo_q;
  assign action_o      = act_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign correction_o  = corr_q;

`ifndef SYNTHESIS
  // Input side only stalls when the whole pipe is full behind a held result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && v1_q && v2_q && v3_q && v4_q))
    else $error("request side stalled without a full, blocked pipeline");

  // Anything other than a new command carries zero speeds and correction
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o != ACT_CMD)) |->
      (left_speed_o == '0 && right_speed_o == '0 && correction_o == '0))
    else $error("non-command result with nonzero speed fields");

  // A taken result with an empty stage behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !v4_q) |=> !out_valid_o)
    else $error("result appeared with no request in the last stage");
`endif

endmodule

>>> sim/wheel_cmd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the yaw PD differential mixer: mirrors the register writes,
// predicts one wheel command per accepted request and checks every result.
// Depends on ypdm_pkg for the register map, the action codes and cfg_t.
module wheel_cmd_checker
  import ypdm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic signed [15:0]    current_yaw_i,
  input  logic signed [18:0]    yaw_rate_i,
  input  logic                  gyro_ready_i,
  input  logic [15:0]           period_us_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  action_e               action_i,
  input  logic signed [12:0]    left_speed_i,
  input  logic signed [12:0]    right_speed_i,
  input  logic signed [12:0]    correction_i,
  output int                    errors_o,
  output int                    pending_o
);

  // 0.01 degree angle units, Q8.8 gain times 0.01 degree gives scale 25600
  localparam int     YAW_HALF   = 18000;
  localparam int     YAW_FULL   = 36000;
  localparam longint Q_SCALE    = 25600;
  localparam longint ROUND_HALF = 12800;

  typedef struct packed {
    action_e            action;
    logic signed [12:0] left;
    logic signed [12:0] right;
    logic signed [12:0] corr;
  } wheel_cmd_t;

  cfg_t       regs;
  wheel_cmd_t wheel_cmd_q[$];
  int         n_bad = 0;
  int         n_pending = 0;

  assign errors_o  = n_bad;
  assign pending_o = n_pending;

  function automatic int wrap_yaw(int a);
    while (a > YAW_HALF) a -= YAW_FULL;
    while (a < -YAW_HALF) a += YAW_FULL;
    return a;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // PD steering correction and differential mix for one tick
  function automatic wheel_cmd_t predict_cmd(cfg_t c, logic signed [15:0] yaw,
                                             logic signed [18:0] rate, logic rdy,
                                             logic [15:0] period);
    wheel_cmd_t r;
    longint     err;
    longint     num;
    longint     mag;
    longint     corr;
    r.action = ACT_NONE;
    r.left   = '0;
    r.right  = '0;
    r.corr   = '0;
    if (!c.enable || period == 16'd0) return r;
    if (!rdy) begin
      r.action = ACT_ZERO;
      return r;
    end
    err = wrap_yaw(int'(c.target_yaw) - int'(yaw));
    num = longint'(c.prop_gain) * err - longint'(c.rate_gain) * longint'(rate);
    if (c.invert_direction) num = -num;
    // round half away from zero
    mag  = (num < 0) ? -num : num;
    mag  = (mag + ROUND_HALF) / Q_SCALE;
    corr = clamp_to((num < 0) ? -mag : mag, c.correction_limit);
    r.action = ACT_CMD;
    r.corr   = 13'(corr);
    r.left   = 13'(clamp_to(c.base_speed - corr, c.target_limit));
    r.right  = 13'(clamp_to(c.base_speed + corr, c.target_limit));
    return r;
  endfunction

  task automatic report(string msg);
    n_bad++;
    if (n_bad <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Sample both channels and the register port at each rising edge
  always @(posedge clk_i) begin : monitor
    wheel_cmd_t exp_cmd;
    if (!rst_ni) begin
      regs = '0;
      wheel_cmd_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_ENABLE: regs.enable = cfg_data_i[0];
          REG_TARGET: regs.target_yaw = 16'(wrap_yaw(int'($signed(cfg_data_i))));
          // base is clamped against the limit held at the time of the write
          REG_BASE:   regs.base_speed = 13'(clamp_to(longint'($signed(cfg_data_i[12:0])),
                                                     regs.target_limit));
          REG_PGAIN:  regs.prop_gain = cfg_data_i;
          REG_RGAIN:  regs.rate_gain = cfg_data_i;
          REG_INVERT: regs.invert_direction = cfg_data_i[0];
          REG_CLIMIT: regs.correction_limit = cfg_data_i[11:0];
          REG_TLIMIT: regs.target_limit = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (wheel_cmd_q.size() == 0) begin
          report($sformatf("result with no request waiting: action %0d left %0d right %0d corr %0d",
                           action_i, left_speed_i, right_speed_i, correction_i));
        end else begin
          exp_cmd = wheel_cmd_q.pop_front();
          if (action_i !== exp_cmd.action || left_speed_i !== exp_cmd.left ||
              right_speed_i !== exp_cmd.right || correction_i !== exp_cmd.corr) begin
            report($sformatf({"mismatch: exp action %0d left %0d right %0d corr %0d,",
                              " got action %0d left %0d right %0d corr %0d"},
                             exp_cmd.action, exp_cmd.left, exp_cmd.right, exp_cmd.corr,
                             action_i, left_speed_i, right_speed_i, correction_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        wheel_cmd_q.push_back(predict_cmd(regs, current_yaw_i, yaw_rate_i,
                                          gyro_ready_i, period_us_i));
      end
    end
    n_pending = wheel_cmd_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for yaw_pd_differential_mixer: clock, reset, register writes,
// request and result traffic, and the verdict. Uses ypdm_pkg and wheel_cmd_checker.
module tb;
  import ypdm_pkg::*;

  localparam int LATENCY      = 5;
  localparam int RANDOM_TICKS = 880;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [18:0] rate;
    logic               rdy;
    logic [15:0]        period;
  } tick_t;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_e;
  typedef enum logic [1:0] {SET_RANDOM, SET_MAX, SET_MIN} set_flavour_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [15:0]    cur_yaw;
  logic signed [18:0]    yaw_rate;
  logic                  gyro_rdy;
  logic [15:0]           period_us;
  logic                  out_valid;
  logic                  out_ready;
  action_e               action;
  logic signed [12:0]    left_speed;
  logic signed [12:0]    right_speed;
  logic signed [12:0]    correction;
  int                    mismatches;
  int                    pending;
  int                    ticks_sent = 0;

  yaw_pd_differential_mixer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .current_yaw_i (cur_yaw),
    .yaw_rate_i    (yaw_rate),
    .gyro_ready_i  (gyro_rdy),
    .period_us_i   (period_us),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .action_o      (action),
    .left_speed_o  (left_speed),
    .right_speed_o (right_speed),
    .correction_o  (correction)
  );

  wheel_cmd_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .current_yaw_i (cur_yaw),
    .yaw_rate_i    (yaw_rate),
    .gyro_ready_i  (gyro_rdy),
    .period_us_i   (period_us),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .action_i      (action),
    .left_speed_i  (left_speed),
    .right_speed_i (right_speed),
    .correction_i  (correction),
    .errors_o      (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Offer one request and hold it until accepted
  task automatic send_tick(tick_t t);
    @(negedge clk);
    cur_yaw   = t.yaw;
    yaw_rate  = t.rate;
    gyro_rdy  = t.rdy;
    period_us = t.period;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop requesting and wait for every outstanding result
  task automatic settle();
    pause_sender(0);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic tick_t mk_tick(int y, int r, logic g, int p);
    tick_t t;
    t.yaw    = 16'(y);
    t.rate   = 19'(r);
    t.rdy    = g;
    t.period = 16'(p);
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    pick;
    pick  = $urandom_range(0, 9);
    t.yaw = (pick < 8) ? 16'(int'($urandom_range(0, 36000)) - 18000) : 16'($urandom);
    pick  = $urandom_range(0, 9);
    if (pick < 6) t.rate = 19'(int'($urandom_range(0, 4000)) - 2000);
    else if (pick < 8) t.rate = 19'(int'($urandom_range(0, 400000)) - 200000);
    else t.rate = 19'($urandom);
    t.rdy    = ($urandom_range(0, 15) != 0);
    t.period = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
    return t;
  endfunction

  // Full register set; in the random flavour unused upper data bits are left random
  task automatic rand_settings(set_flavour_e flavour);
    logic [15:0] en, tgt, base, pg, rg, inv, cl, tl;
    case (flavour)
      SET_MAX: begin
        en = 16'd1; tgt = 16'(18000); base = 16'(4095); pg = 16'hFFFF; rg = 16'hFFFF;
        inv = 16'd1; cl = 16'h0FFF; tl = 16'h0FFF;
      end
      SET_MIN: begin
        en = 16'd1; tgt = 16'(-18000); base = 16'h1000; pg = 16'd0; rg = 16'd0;
        inv = 16'd0; cl = 16'd0; tl = 16'd0;
      end
      default: begin
        en    = 16'($urandom);
        en[0] = ($urandom_range(0, 7) != 0);
        tgt   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'(int'($urandom_range(0, 36000)) - 18000);
        base  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                            : 16'(int'($urandom_range(0, 2000)) - 1000);
        pg    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        rg    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        inv   = 16'($urandom);
        cl    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(50, 1500));
        tl    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(500, 4000));
      end
    endcase
    // limit first sometimes, so the base clamp sees either the old or new limit
    if ($urandom_range(0, 1) == 0) write_reg(REG_TLIMIT, tl);
    write_reg(REG_ENABLE, en);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_BASE, base);
    write_reg(REG_PGAIN, pg);
    write_reg(REG_RGAIN, rg);
    write_reg(REG_INVERT, inv);
    write_reg(REG_CLIMIT, cl);
    write_reg(REG_TLIMIT, tl);
  endtask

  // Result side: stall pattern plus one long hold-off to back up the pipe
  initial begin : result_sink
    rx_mode_e mode;
    int       seg_left;
    int       hold_left;
    bit       held;
    mode      = RX_FREE;
    seg_left  = 0;
    hold_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && ticks_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(4, 60);
        end
        seg_left--;
        case (mode)
          RX_FREE:   out_ready = 1'b1;
          RX_CHOPPY: out_ready = $urandom_range(0, 1);
          default:   out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Request side and verdict
  initial begin : request_source
    set_flavour_e flavour;
    int           done;
    int           phase;
    int           chunk;
    int           burst_left;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cur_yaw   = '0;
    yaw_rate  = '0;
    gyro_rdy  = 1'b0;
    period_us = '0;
    done      = 0;
    phase     = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: loop disabled, no update
    send_tick(mk_tick(0, 0, 1'b1, 1000));
    send_tick(mk_tick(1234, -500, 1'b1, 65535));
    settle();

    // unit gain: rounding around half a step, yaw wrap, gyro and period cases
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_TARGET, 16'd0);
    write_reg(REG_TLIMIT, 16'd3000);
    write_reg(REG_BASE, 16'd1000);
    write_reg(REG_PGAIN, 16'd256);
    write_reg(REG_RGAIN, 16'd0);
    write_reg(REG_INVERT, 16'd0);
    write_reg(REG_CLIMIT, 16'd4000);
    send_tick(mk_tick(-50, 0, 1'b1, 1000));
    send_tick(mk_tick(50, 0, 1'b1, 1000));
    send_tick(mk_tick(-49, 0, 1'b1, 1000));
    send_tick(mk_tick(18000, 0, 1'b1, 1000));
    send_tick(mk_tick(-18000, 0, 1'b1, 1000));
    send_tick(mk_tick(32767, 0, 1'b1, 1000));
    send_tick(mk_tick(-32768, 0, 1'b1, 1000));
    send_tick(mk_tick(500, 0, 1'b0, 1000));
    send_tick(mk_tick(500, 0, 1'b1, 0));
    send_tick(mk_tick(500, 0, 1'b1, 65535));
    settle();

    // full gains, inverted, target wrapped on write, base clamped on write
    write_reg(REG_TLIMIT, 16'd4095);
    write_reg(REG_BASE, 16'h1000);
    write_reg(REG_TARGET, 16'd30000);
    write_reg(REG_PGAIN, 16'hFFFF);
    write_reg(REG_RGAIN, 16'hFFFF);
    write_reg(REG_INVERT, 16'd1);
    write_reg(REG_CLIMIT, 16'd4095);
    send_tick(mk_tick(0, 262143, 1'b1, 1));
    send_tick(mk_tick(0, -262144, 1'b1, 1));
    send_tick(mk_tick(-6000, 0, 1'b1, 1));
    settle();

    // base clamped by a low limit, then the limit raised again
    write_reg(REG_TLIMIT, 16'd500);
    write_reg(REG_BASE, 16'd2000);
    write_reg(REG_TLIMIT, 16'd4000);
    write_reg(REG_TARGET, 16'(-18000));
    write_reg(REG_PGAIN, 16'd2560);
    write_reg(REG_RGAIN, 16'd128);
    write_reg(REG_INVERT, 16'd0);
    write_reg(REG_CLIMIT, 16'd300);
    send_tick(mk_tick(17000, 300, 1'b1, 20000));
    send_tick(mk_tick(-17000, -300, 1'b1, 20000));
    send_tick(mk_tick(0, 100000, 1'b1, 5));
    send_tick(mk_tick(18000, 0, 1'b1, 1));
    settle();
    write_reg(REG_ENABLE, 16'd0);
    send_tick(mk_tick(100, 100, 1'b1, 100));

    // random phases, each under its own register settings, requests in bursts
    while (done < RANDOM_TICKS) begin
      settle();
      case (phase)
        1:       flavour = SET_MAX;
        3:       flavour = SET_MIN;
        default: flavour = SET_RANDOM;
      endcase
      rand_settings(flavour);
      chunk      = $urandom_range(60, 120);
      burst_left = $urandom_range(1, 20);
      repeat (chunk) begin
        send_tick(rand_tick());
        done++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 20);
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 6));
        end
      end
      phase++;
    end

    settle();
    repeat (4 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
